// ===== src/amdfs_pkg.sv =====
// Package for the adjacency matrix depth-first order unit.
// Holds sizes, payload structs, function codes, sequencer states and index helpers.
// No dependencies.
package amdfs_pkg;

    localparam int VERTICES     = 16;
    localparam int STACK_DEPTH  = 256;
    localparam int MAX_RESULTS  = 16;

    localparam int FUNC_W       = 2;
    localparam int VTX_W        = 5;
    localparam int ROW_W        = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int IX_W         = (ROW_W > VTX_W) ? ROW_W : VTX_W;
    localparam int SA_W         = $clog2(STACK_DEPTH);
    localparam int SP_W         = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [VTX_W-1:0] VCOUNT_RESET = VTX_W'(16);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_EDGE   = 2'd1,
        FUNC_SEARCH = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_POP,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VTX_W-1:0]  edge_from;
        logic [VTX_W-1:0]  edge_to;
        logic [VTX_W-1:0]  start_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] visited_vertex;
        logic             last_visit;
        logic             start_error;
    } t_out_item;

    function automatic logic [ROW_W-1:0] f_vidx(input logic [VTX_W-1:0] v);
        logic [IX_W-1:0] t;
        t = IX_W'(v) - IX_W'(1);
        return t[ROW_W-1:0];
    endfunction

    function automatic logic f_in_matrix(input logic [VTX_W-1:0] v);
        return (v != '0) && (32'(v) <= VERTICES);
    endfunction

endpackage

// ===== src/adjacency_matrix_dfs_order_unit.sv =====
// Directed adjacency matrix store with an iterative stack depth-first walk.
// Matrix rows and the pending stack sit in synchronous memories with registered reads.
// Depends on amdfs_pkg.
// Clear and add-edge leave the unit idle; a transfer is accepted every cycle while idle.
// Search: an accept step, then per pop a stack read and a check, a successor scan per
// visited vertex (one matrix bit a cycle, at most one stack push each), and a finish
// step; a complete graph pops 1 + n*(n-1)/2 entries.
// Results leave through an output register; the next search waits for the last one.
// Reset: matrix reads as empty through row valid bits, vertex_count is 16, no clearing pass.
module adjacency_matrix_dfs_order_unit
    import amdfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [VERTICES-1:0] r_adj_mem [VERTICES];
    logic [VTX_W-1:0]    r_stk_mem [STACK_DEPTH];

    t_state              r_state,        n_state;
    logic [SP_W-1:0]     r_sp,           n_sp;
    logic [VERTICES-1:0] r_visited,      n_visited;
    logic [VTX_W-1:0]    r_w,            n_w;
    logic                r_pend_valid,   n_pend_valid;
    logic [VTX_W-1:0]    r_pend_vertex,  n_pend_vertex;
    logic [CNT_W-1:0]    r_cnt,          n_cnt;
    logic                r_out_valid;
    t_out_item           r_out;
    logic [VTX_W-1:0]    r_vertex_count;
    logic [VERTICES-1:0] r_row_valid;
    logic [VERTICES-1:0] r_adj_q;
    logic                r_adj_qv;
    logic [VTX_W-1:0]    r_stk_q;

    logic                w_out_free;
    logic                w_out_load;
    t_out_item           w_out_next;
    logic [VTX_W-1:0]    w_n;
    logic [VERTICES-1:0] w_row;
    logic [ROW_W-1:0]    w_h_idx;
    logic [ROW_W-1:0]    w_w_idx;
    logic                w_adj_we;
    logic                w_adj_clear;
    logic                w_adj_re;
    logic                w_stk_we;
    logic [SA_W-1:0]     w_stk_waddr;
    logic [VTX_W-1:0]    w_stk_wdata;
    logic                w_stk_re;
    logic [ROW_W-1:0]    w_from_idx;
    logic [ROW_W-1:0]    w_to_idx;
    logic [SP_W-1:0]     w_sp_dec;

    assign w_n        = (32'(r_vertex_count) < VERTICES) ? r_vertex_count : VTX_W'(VERTICES);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_row      = r_adj_qv ? r_adj_q : '0;
    assign w_h_idx    = f_vidx(r_stk_q);
    assign w_w_idx    = f_vidx(r_w);
    assign w_from_idx = f_vidx(i_in_data.edge_from);
    assign w_to_idx   = f_vidx(i_in_data.edge_to);
    assign w_sp_dec   = r_sp - SP_W'(1);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : 32'(r_vertex_count);

    always_comb begin
        n_state       = r_state;
        n_sp          = r_sp;
        n_visited     = r_visited;
        n_w           = r_w;
        n_pend_valid  = r_pend_valid;
        n_pend_vertex = r_pend_vertex;
        n_cnt         = r_cnt;
        w_out_load    = 1'b0;
        w_out_next    = '0;
        w_adj_we      = 1'b0;
        w_adj_clear   = 1'b0;
        w_adj_re      = 1'b0;
        w_stk_we      = 1'b0;
        w_stk_waddr   = r_sp[SA_W-1:0];
        w_stk_wdata   = r_w;
        w_stk_re      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.func)
                        FUNC_CLEAR: begin
                            w_adj_clear = 1'b1;
                        end
                        FUNC_EDGE: begin
                            w_adj_we = f_in_matrix(i_in_data.edge_from) &&
                                       f_in_matrix(i_in_data.edge_to);
                        end
                        FUNC_SEARCH: begin
                            if (i_in_data.start_vertex != '0 &&
                                i_in_data.start_vertex <= w_n) begin
                                w_stk_we     = 1'b1;
                                w_stk_waddr  = '0;
                                w_stk_wdata  = i_in_data.start_vertex;
                                n_sp         = SP_W'(1);
                                n_visited    = '0;
                                n_pend_valid = 1'b0;
                                n_cnt        = '0;
                                n_state      = ST_POP;
                            end else begin
                                n_state = ST_ERR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    w_out_load                = 1'b1;
                    w_out_next.visited_vertex = '0;
                    w_out_next.last_visit     = 1'b1;
                    w_out_next.start_error    = 1'b1;
                    n_state                   = ST_IDLE;
                end
            end
            ST_POP: begin
                if (r_sp == '0) begin
                    n_state = ST_DONE;
                end else begin
                    w_stk_re = 1'b1;
                    n_sp     = w_sp_dec;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_stk_q == '0 || r_stk_q > w_n || r_visited[w_h_idx]) begin
                    n_state = ST_POP;
                end else if (r_pend_valid && 32'(r_cnt) < MAX_RESULTS && !w_out_free) begin
                    n_state = ST_CHECK;
                end else begin
                    n_visited[w_h_idx] = 1'b1;
                    w_adj_re           = 1'b1;
                    n_w                = w_n;
                    n_state            = ST_SCAN;
                    if (32'(r_cnt) < MAX_RESULTS) begin
                        if (r_pend_valid) begin
                            w_out_load                = 1'b1;
                            w_out_next.visited_vertex = r_pend_vertex;
                        end
                        n_pend_valid  = 1'b1;
                        n_pend_vertex = r_stk_q;
                        n_cnt         = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (w_row[w_w_idx] && !r_visited[w_w_idx] && 32'(r_sp) < STACK_DEPTH) begin
                    w_stk_we = 1'b1;
                    n_sp     = r_sp + SP_W'(1);
                end
                if (r_w == VTX_W'(1)) begin
                    n_state = ST_POP;
                end else begin
                    n_w = r_w - VTX_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_out_load                = 1'b1;
                    w_out_next.visited_vertex = r_pend_vertex;
                    w_out_next.last_visit     = 1'b1;
                    n_pend_valid              = 1'b0;
                    n_state                   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sp           <= '0;
            r_visited      <= '0;
            r_pend_valid   <= 1'b0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_vertex_count <= VCOUNT_RESET;
            r_row_valid    <= '0;
        end else begin
            r_state      <= n_state;
            r_sp         <= n_sp;
            r_visited    <= n_visited;
            r_pend_valid <= n_pend_valid;
            r_cnt        <= n_cnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && !paddr[2]) begin
                r_vertex_count <= pwdata[VTX_W-1:0];
            end
            if (w_adj_clear) begin
                r_row_valid <= '0;
            end else if (w_adj_we) begin
                r_row_valid[w_from_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w           <= n_w;
        r_pend_vertex <= n_pend_vertex;
        if (w_out_load) begin
            r_out <= w_out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            if (r_row_valid[w_from_idx]) begin
                r_adj_mem[w_from_idx][w_to_idx] <= 1'b1;
            end else begin
                r_adj_mem[w_from_idx] <= VERTICES'(1) << w_to_idx;
            end
        end
        if (w_adj_re) begin
            r_adj_q  <= r_adj_mem[w_h_idx];
            r_adj_qv <= r_row_valid[w_h_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_waddr] <= w_stk_wdata;
        end
        if (w_stk_re) begin
            r_stk_q <= r_stk_mem[w_sp_dec[SA_W-1:0]];
        end
    end

endmodule
